// ===== src/dtsd_pkg.sv =====
// Package for the date to serial day number core: types, constants, calendar helpers.
// No dependencies; used by dtsd_year and date_to_serial_day_number_core.
`timescale 1ns / 1ps
`default_nettype none
package dtsd_pkg;

   localparam int unsigned YEAR_W   = 14;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned SERIAL_W = 22;
   localparam int unsigned ERR_W    = 2;
   localparam int unsigned LEAPS_W  = 12;

   localparam logic [YEAR_W-1:0] FIRST_YEAR = 14'd1900;
   localparam logic [YEAR_W-1:0] LAST_YEAR  = 14'd9999;

   // Gregorian leap years in 1..1899
   localparam logic [LEAPS_W-1:0] LEAPS_BEFORE_FIRST = 12'd460;

   // 1311 / 2^15 is a slightly high 1/25, exact for quotients below 4096
   localparam logic [10:0] RECIP_25    = 11'd1311;
   localparam int unsigned RECIP_SHIFT = 15;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_YEAR  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_MONTH = 2'd2;
   localparam logic [ERR_W-1:0] ERR_DAY   = 2'd3;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic                year_ok;
      logic                leap;
      logic [SERIAL_W-1:0] days_before;
   } year_info_type;

   // n/4 - n/100 + n/400, with n/100 taken as (n/4)/25
   function automatic logic [LEAPS_W-1:0] leaps_through(input logic [YEAR_W-1:0] n);
      logic [11:0] q4;
      logic [22:0] prod;
      logic [7:0]  q100;
      logic [5:0]  q400;
      begin
         q4   = n[YEAR_W-1:2];
         prod = 23'(q4) * 23'(RECIP_25);
         q100 = prod[22:RECIP_SHIFT];
         q400 = q100[7:2];
         return q4 - LEAPS_W'(q100) + LEAPS_W'(q400);
      end
   endfunction

   // Days before the first of the month in a common year
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
      case (m)
         4'd1:    return 9'd0;
         4'd2:    return 9'd31;
         4'd3:    return 9'd59;
         4'd4:    return 9'd90;
         4'd5:    return 9'd120;
         4'd6:    return 9'd151;
         4'd7:    return 9'd181;
         4'd8:    return 9'd212;
         4'd9:    return 9'd243;
         4'd10:   return 9'd273;
         4'd11:   return 9'd304;
         4'd12:   return 9'd334;
         default: return 9'd0;
      endcase
   endfunction

   // Month length, February extended in leap years
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      case (m)
         4'd2:                  return leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
         default:               return 5'd31;
      endcase
   endfunction

endpackage
`default_nettype wire

// ===== src/dtsd_year.sv =====
// Year part of the conversion: range check, leap flag, days before 1 Jan of the year.
// Depends on dtsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dtsd_year (
   input  wire logic [dtsd_pkg::YEAR_W-1:0] year,
   output dtsd_pkg::year_info_type          info
);
   import dtsd_pkg::*;

   logic [YEAR_W-1:0]   year_prev;
   logic [LEAPS_W-1:0]  leaps_cur;
   logic [LEAPS_W-1:0]  leaps_prev;
   logic [YEAR_W-1:0]   year_off;
   logic                is_first;

   assign year_prev  = year - YEAR_W'(1);
   assign leaps_cur  = leaps_through(year);
   assign leaps_prev = leaps_through(year_prev);
   assign year_off   = year - FIRST_YEAR;
   assign is_first   = (year == FIRST_YEAR);

   always_comb begin
      info.year_ok = (year >= FIRST_YEAR) && (year <= LAST_YEAR);
      // 1900 counted leap by convention
      info.leap    = is_first || (leaps_cur != leaps_prev);
      if (is_first) begin
         info.days_before = '0;
      end else begin
         // the extra 1 is the 1900 leap day
         info.days_before = SERIAL_W'(year_off) * SERIAL_W'(365) + SERIAL_W'(1)
                          + SERIAL_W'(leaps_prev) - SERIAL_W'(LEAPS_BEFORE_FIRST);
      end
   end

endmodule
`default_nettype wire

// ===== src/date_to_serial_day_number_core.sv =====
// Top level of the date to serial day number core.
// Depends on dtsd_pkg and dtsd_year.
`timescale 1ns / 1ps
`default_nettype none
// Converts a calendar date to its serial day number, 1 Jan 1900 being day 1,
// with 1900 counted as a leap year (29 Feb 1900 is day 60).
//
// Input: drive req_year/req_month/req_day and raise start; the item is taken
// on the rising edge where start is high and busy is low. busy is high only
// while reset is held, so one item is taken every cycle otherwise.
//
// Output: each item gives exactly one result, shown on rsp_serial_day and
// rsp_error_code for one cycle with rsp_valid high. There is no back
// pressure; the receiver must take the result in that cycle.
//
// Throughput: one item per cycle. Three register stages: input capture,
// year stage (leap count through a 1/25 reciprocal multiply and the
// 365-per-year term), then month/day check and final sum.
//
// Errors, first failing check wins: 1 bad year (outside 1900..9999),
// 2 bad month, 3 bad day; serial is 0 on any error.
// Reset (synchronous) clears the valid pipeline; items in flight are dropped.
module date_to_serial_day_number_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [dtsd_pkg::YEAR_W-1:0]     req_year,
   input  wire logic [dtsd_pkg::MONTH_W-1:0]    req_month,
   input  wire logic [dtsd_pkg::DAY_W-1:0]      req_day,
   output logic                                 rsp_valid,
   output logic [dtsd_pkg::SERIAL_W-1:0]        rsp_serial_day,
   output logic [dtsd_pkg::ERR_W-1:0]           rsp_error_code
);
   import dtsd_pkg::*;

   // ---- stage 0: input capture ----
   logic                 in_valid_ff, in_valid_in;
   logic [YEAR_W-1:0]    in_year_ff;
   logic [MONTH_W-1:0]   in_month_ff;
   logic [DAY_W-1:0]     in_day_ff;

   // ---- stage 1: year done ----
   logic                 yr_valid_ff, yr_valid_in;
   year_info_type        yr_info_ff, yr_info_in;
   logic [MONTH_W-1:0]   yr_month_ff;
   logic [DAY_W-1:0]     yr_day_ff;

   // ---- stage 2: result ----
   logic                 out_valid_ff, out_valid_in;
   logic [SERIAL_W-1:0]  out_serial_ff, out_serial_in;
   logic [ERR_W-1:0]     out_err_ff, out_err_in;

   logic                 month_ok;
   logic                 day_ok;
   logic                 extra_day;
   logic [DAY_W-1:0]     len;

   // Only reset holds off input
   assign busy        = reset;
   assign in_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_year_ff  <= req_year;
      in_month_ff <= req_month;
      in_day_ff   <= req_day;
   end

   dtsd_year u_year (
      .year (in_year_ff),
      .info (yr_info_in)
   );

   assign yr_valid_in = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         yr_valid_ff <= 1'b0;
      end else begin
         yr_valid_ff <= yr_valid_in;
      end
      yr_info_ff  <= yr_info_in;
      yr_month_ff <= in_month_ff;
      yr_day_ff   <= in_day_ff;
   end

   // Month and day check, then the final sum
   assign month_ok  = (yr_month_ff >= MONTH_JAN) && (yr_month_ff <= MONTH_DEC);
   assign len       = month_days(yr_month_ff, yr_info_ff.leap);
   assign day_ok    = (yr_day_ff != '0) && (yr_day_ff <= len);
   assign extra_day = yr_info_ff.leap && (yr_month_ff > MONTH_FEB);

   always_comb begin
      out_valid_in  = yr_valid_ff;
      out_serial_in = '0;
      if (!yr_info_ff.year_ok) begin
         out_err_in = ERR_YEAR;
      end else if (!month_ok) begin
         out_err_in = ERR_MONTH;
      end else if (!day_ok) begin
         out_err_in = ERR_DAY;
      end else begin
         out_err_in    = ERR_NONE;
         out_serial_in = yr_info_ff.days_before + SERIAL_W'(month_start(yr_month_ff))
                       + SERIAL_W'(extra_day) + SERIAL_W'(yr_day_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_serial_ff <= out_serial_in;
      out_err_ff    <= out_err_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_serial_day = out_serial_ff;
   assign rsp_error_code = out_err_ff;

endmodule
`default_nettype wire

// ===== src/dtsd_checker.sv =====
// Port-level checks for date_to_serial_day_number_core, bound to the top level.
// Depends on dtsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dtsd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic                            rsp_valid,
   input wire logic [dtsd_pkg::SERIAL_W-1:0]   rsp_serial_day,
   input wire logic [dtsd_pkg::ERR_W-1:0]      rsp_error_code
);
   import dtsd_pkg::*;

   // every accepted item is answered on rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("missing result three cycles after accept");

   // no result without a matching accepted item
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result without matching item");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE) |-> (rsp_serial_day == '0))
      else $error("nonzero serial on error");

   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code == ERR_NONE) |->
         (rsp_serial_day != '0 && rsp_serial_day <= SERIAL_W'(2958465)))
      else $error("serial out of range");

endmodule

bind date_to_serial_day_number_core dtsd_checker u_dtsd_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_serial_day (rsp_serial_day),
   .rsp_error_code (rsp_error_code)
);
`default_nettype wire
